/* hw/rtl/pmfe_pkg.sv */
package pmfe_pkg;

  localparam int unsigned ADDRESS_BITS_DEF = 40;

  localparam int unsigned SEED_W  = 64;
  localparam int unsigned PAGE_W  = 17;
  localparam int unsigned IDX_W   = 38;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned PCT_W   = 7;
  // quotient never exceeds 100, so seven quotient bits cover it
  localparam int unsigned QUOT_W  = 7;
  // (index + 1) * 100 fits in index width plus seven bits
  localparam int unsigned DIV_W   = IDX_W + QUOT_W;
  localparam int unsigned CNT_W   = $clog2(PAGE_W);
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [SEED_W-1:0] SEED_RST  = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [PAGE_W-1:0] PAGE_RST  = 17'd4096;
  localparam logic [IDX_W-1:0]  TOTAL_RST = 38'd1;
  localparam logic [STEP_W-1:0] STEP_RST  = 7'd5;
  localparam logic [STEP_W-1:0] STEP_FALLBACK = 7'd5;
  localparam logic [STEP_W-1:0] STEP_MAX  = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
  localparam logic [PAGE_W-1:0] WORD_BYTES = 17'd8;

  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 7;
  localparam int unsigned XS_C = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED  = 3'd0,
    REG_MODE  = 3'd1,
    REG_PAGE  = 3'd2,
    REG_TOTAL = 3'd3,
    REG_STEP  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_EMIT
  } fsm_e;

  function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] a;
    logic [SEED_W-1:0] b;
    a = x ^ (x << XS_A);
    b = a ^ (a >> XS_B);
    return b ^ (b << XS_C);
  endfunction

  function automatic logic [THR_W-1:0] first_thr(input logic [STEP_W-1:0] step);
    if (step == '0 || step > STEP_MAX) begin
      return THR_W'(STEP_FALLBACK);
    end
    return THR_W'(step);
  endfunction

endpackage

/* hw/rtl/prng_memory_fill_engine_unit.sv */
// Memory fill pattern engine. Each accepted request (restart bit) performs one
// element step: a 64-bit xorshift word, its byte address (index times 8, or
// index times page size in page mode, wrapping at ADDRESS_BITS), the running
// XOR checksum, the completion percent and a progress flag, delivered as one
// result. A request passes through a load state, then the bit-serial shift-add
// multiplier that walks the 17-bit page size (the 7-step restoring divider for
// the percent runs alongside it), then an emit state that registers the result
// once the output register is free; a request past the end of the fill goes
// from the load state straight to the emit state. A new request is taken as
// soon as the result sits in the output register, even if it has not been
// taken yet; no new request is taken while one is still being worked on.
// Configuration writes are taken at any time and must be made while idle.
module prng_memory_fill_engine_unit
  import pmfe_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [SEED_W-1:0]       cfg_data_i,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    restart_i,

  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    write_enable_o,
  output logic [ADDRESS_BITS-1:0] write_address_o,
  output logic [SEED_W-1:0]       write_data_o,
  output logic [SEED_W-1:0]       running_checksum_o,
  output logic                    progress_hit_o,
  output logic [PCT_W-1:0]        percent_done_o,
  output logic                    fill_done_o
);

  // configuration registers
  logic [SEED_W-1:0] seed_q;
  logic              mode_q;
  logic [PAGE_W-1:0] page_q;
  logic [IDX_W-1:0]  total_q;
  logic [STEP_W-1:0] step_q;

  // fill state
  logic [SEED_W-1:0] gen_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SEED_W-1:0] chk_q;
  logic [THR_W-1:0]  thr_q;
  logic              fin_q;

  // working registers
  fsm_e                    state_q, state_d;
  logic                    idle_q;
  logic [SEED_W-1:0]       val_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [PAGE_W-1:0]       mcand_q;
  logic [ADDRESS_BITS-1:0] idx_sh_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [DIV_W-1:0]        rem_q;
  logic [DIV_W-1:0]        dvs_q;
  logic [QUOT_W-1:0]       quot_q;

  logic                    out_valid_q;

  logic                    in_acc;
  logic                    out_free;
  logic                    emit;
  logic [IDX_W:0]          pos;
  logic [DIV_W-1:0]        pos_w;
  logic                    div_ge;
  logic                    hit;
  logic [SEED_W-1:0]       chk_new;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = (state_q == ST_EMIT) && out_free;
  assign out_valid_o = out_valid_q;

  assign pos     = {1'b0, idx_q} + (IDX_W + 1)'(1);
  assign pos_w   = DIV_W'(pos);
  assign div_ge  = rem_q >= dvs_q;
  assign hit     = {1'b0, quot_q} >= thr_q;
  assign chk_new = chk_q ^ val_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (fin_q || idx_q >= total_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (cnt_q == CNT_W'(PAGE_W - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= SEED_RST;
      mode_q  <= 1'b0;
      page_q  <= PAGE_RST;
      total_q <= TOTAL_RST;
      step_q  <= STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SEED:  seed_q  <= cfg_data_i;
        REG_MODE:  mode_q  <= cfg_data_i[0];
        REG_PAGE:  page_q  <= cfg_data_i[PAGE_W-1:0];
        REG_TOTAL: total_q <= cfg_data_i[IDX_W-1:0];
        REG_STEP:  step_q  <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // fill state: restart on an accepted restart request, advance when a write result is emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= SEED_RST;
      idx_q <= '0;
      chk_q <= '0;
      thr_q <= first_thr(STEP_RST);
      fin_q <= 1'b0;
    end else if (in_acc && restart_i) begin
      gen_q <= seed_q;
      idx_q <= '0;
      chk_q <= '0;
      thr_q <= first_thr(step_q);
      fin_q <= 1'b0;
    end else if (emit && !idle_q) begin
      gen_q <= val_q;
      idx_q <= pos[IDX_W-1:0];
      chk_q <= chk_new;
      fin_q <= pos >= {1'b0, total_q};
      if (hit) begin
        thr_q <= thr_q + THR_W'(step_q);
      end
    end
  end

  // serial multiplier and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= 1'b0;
      cnt_q  <= '0;
    end else if (state_q == ST_LOAD) begin
      idle_q <= fin_q || idx_q >= total_q;
      cnt_q  <= '0;
    end else if (state_q == ST_CALC) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      val_q    <= xorshift(gen_q);
      mcand_q  <= mode_q ? page_q : WORD_BYTES;
      idx_sh_q <= ADDRESS_BITS'(idx_q);
      addr_q   <= '0;
      // (index + 1) * 100 as 64 + 32 + 4
      rem_q    <= (pos_w << 6) + (pos_w << 5) + (pos_w << 2);
      dvs_q    <= DIV_W'(total_q) << (QUOT_W - 1);
      quot_q   <= '0;
    end else if (state_q == ST_CALC) begin
      if (mcand_q[0]) begin
        addr_q <= addr_q + idx_sh_q;
      end
      mcand_q  <= mcand_q >> 1;
      idx_sh_q <= idx_sh_q << 1;
      if (cnt_q < CNT_W'(QUOT_W)) begin
        if (div_ge) begin
          rem_q <= rem_q - dvs_q;
        end
        dvs_q  <= dvs_q >> 1;
        quot_q <= {quot_q[QUOT_W-2:0], div_ge};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (idle_q) begin
        write_enable_o     <= 1'b0;
        write_address_o    <= '0;
        write_data_o       <= '0;
        running_checksum_o <= chk_q;
        progress_hit_o     <= 1'b0;
        percent_done_o     <= PCT_FULL;
        fill_done_o        <= 1'b1;
      end else begin
        write_enable_o     <= 1'b1;
        write_address_o    <= addr_q;
        write_data_o       <= val_q;
        running_checksum_o <= chk_new;
        progress_hit_o     <= hit;
        percent_done_o     <= quot_q;
        fill_done_o        <= pos >= {1'b0, total_q};
      end
    end
  end

endmodule

/* hw/rtl/pmfe_checker.sv */
module pmfe_checker
  import pmfe_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    write_enable_o,
  input logic [ADDRESS_BITS-1:0] write_address_o,
  input logic [SEED_W-1:0]       write_data_o,
  input logic                    progress_hit_o,
  input logic [PCT_W-1:0]        percent_done_o,
  input logic                    fill_done_o
);

  // an accepted request keeps the input closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_data_o)
      && $stable(write_address_o))
    else $error("stalled result changed");

  // a tick with no write reports an idle, finished fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> fill_done_o && !progress_hit_o
      && percent_done_o == PCT_FULL && write_address_o == '0 && write_data_o == '0)
    else $error("idle tick with bad fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> percent_done_o <= PCT_FULL)
    else $error("percent above 100");

  // a finished write reports a complete percent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o && fill_done_o |-> percent_done_o == PCT_FULL)
    else $error("last write without full percent");

endmodule

bind prng_memory_fill_engine_unit pmfe_checker #(
  .ADDRESS_BITS(ADDRESS_BITS)
) u_pmfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .write_enable_o (write_enable_o),
  .write_address_o(write_address_o),
  .write_data_o   (write_data_o),
  .progress_hit_o (progress_hit_o),
  .percent_done_o (percent_done_o),
  .fill_done_o    (fill_done_o)
);
